// ----- hw/rtl/mvp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvp_pkg
// Shared types and constants for the median motion vector predictor.
// ---------------------------------------------------------------------------
package mvp_pkg;

  localparam int MAX_ROW_BLOCKS = 256;
  localparam int ADDR_W         = $clog2(MAX_ROW_BLOCKS);
  localparam int CFG_W          = 9;
  localparam int VEC_W          = 13;
  localparam int CNT_W          = 2;
  // width domain for column and row-width compares
  localparam int CMP_W          = (CFG_W > ADDR_W + 1) ? CFG_W : ADDR_W + 1;
  localparam logic [CFG_W-1:0] BPR_RESET = CFG_W'(80);

  typedef struct packed {
    logic                    motion;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } mv_entry_t;

  localparam int ENTRY_W = $bits(mv_entry_t);

  typedef enum logic {
    OP_FRAME_START = 1'b0,
    OP_COMMIT      = 1'b1
  } op_t;

  typedef struct packed {
    logic col_nonzero;
    logic past_first_row;
    logic tr_ok;
  } nbr_flags_t;

endpackage

// ----- hw/rtl/mvp_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvp_ram
// Generic RAM: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module mvp_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ----- hw/rtl/mvp_predict.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvp_predict
// Neighbor selection and per-axis average / median of the motion neighbors.
// ---------------------------------------------------------------------------
module mvp_predict (
  input  mvp_pkg::mv_entry_t                left_e,
  input  mvp_pkg::mv_entry_t                top_e,
  input  mvp_pkg::mv_entry_t                top_right_e,
  input  mvp_pkg::mv_entry_t                upper_left_e,
  input  mvp_pkg::nbr_flags_t               flags,
  output logic signed [mvp_pkg::VEC_W-1:0]  pred_x,
  output logic signed [mvp_pkg::VEC_W-1:0]  pred_y,
  output logic [mvp_pkg::CNT_W-1:0]         count
);
  import mvp_pkg::*;

  localparam int SUM_W = VEC_W + 2;

  function automatic logic signed [VEC_W-1:0] mid3(
    input logic signed [VEC_W-1:0] a,
    input logic signed [VEC_W-1:0] b,
    input logic signed [VEC_W-1:0] c
  );
    logic signed [VEC_W-1:0] lo;
    logic signed [VEC_W-1:0] hi;
    logic signed [VEC_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  function automatic logic signed [VEC_W-1:0] axis(
    input logic signed [VEC_W-1:0] a,
    input logic signed [VEC_W-1:0] b,
    input logic signed [VEC_W-1:0] c,
    input logic                    va,
    input logic                    vb,
    input logic                    vc,
    input logic [CNT_W-1:0]        n
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] half;
    logic signed [VEC_W-1:0] res;
    // unused candidates contribute zero, so one neighbor is just the sum
    sum = (va ? SUM_W'(a) : '0) + (vb ? SUM_W'(b) : '0) + (vc ? SUM_W'(c) : '0);
    // halve, rounding toward zero
    half = (sum + SUM_W'(sum[SUM_W-1])) >>> 1;
    case (n)
      2'd3:    res = mid3(a, b, c);
      2'd2:    res = half[VEC_W-1:0];
      default: res = sum[VEC_W-1:0];
    endcase
    return res;
  endfunction

  logic      left_v;
  logic      top_v;
  logic      tr_v;
  logic      ul_v;
  logic      third_v;
  mv_entry_t third_e;

  always_comb begin
    left_v  = flags.col_nonzero && left_e.motion;
    top_v   = flags.past_first_row && top_e.motion;
    tr_v    = flags.past_first_row && flags.tr_ok && top_right_e.motion;
    // top-left stands in when top-right is missing or not motion
    ul_v    = !tr_v && flags.past_first_row && flags.col_nonzero && upper_left_e.motion;
    third_v = tr_v || ul_v;
    third_e = tr_v ? top_right_e : upper_left_e;
    count   = CNT_W'(left_v) + CNT_W'(top_v) + CNT_W'(third_v);
    pred_x  = axis(left_e.x, top_e.x, third_e.x, left_v, top_v, third_v, count);
    pred_y  = axis(left_e.y, top_e.y, third_e.y, left_v, top_v, third_v, count);
  end

endmodule

// ----- hw/rtl/mv_median_predictor_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mv_median_predictor_top
// Median motion vector predictor for macroblocks visited in raster order.
// ---------------------------------------------------------------------------
// Each input word either starts a frame (predicts block 0) or commits the
// finished block and predicts the next one; every word gives one result word.
// In the cycle a word is accepted the block is written to the line store
// and the top and top-right entries of the next column are read on the
// store's two read ports; the neighbors are then combined and the result
// goes to the output register once it is free. A new word is taken once
// the previous result is in the output register, also while it waits
// there. blocks_per_row may only be written while the block is idle.
module mv_median_predictor_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mvp_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [mvp_pkg::VEC_W-1:0]   vec_x,
  input  logic signed [mvp_pkg::VEC_W-1:0]   vec_y,
  input  logic                               is_motion,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mvp_pkg::VEC_W-1:0]   pred_x,
  output logic signed [mvp_pkg::VEC_W-1:0]   pred_y,
  output logic [mvp_pkg::CNT_W-1:0]          neighbor_count
);
  import mvp_pkg::*;

  logic [CFG_W-1:0]  blocks_per_row;
  logic [CMP_W-1:0]  eff_w;
  logic [ADDR_W-1:0] column;
  logic [ADDR_W-1:0] column_next;
  logic              past_first_row;
  mv_entry_t         left_entry;
  mv_entry_t         upper_left_entry;
  mv_entry_t         top_hold;
  mv_entry_t         done_e;
  mv_entry_t         fwd_entry;
  logic              fwd_top;
  logic              fwd_tr;
  logic              tr_ok;
  logic              busy;
  logic              accept;
  logic              is_commit;
  logic              wrap;
  logic              finish;
  logic [CMP_W-1:0]  col_inc;
  logic [ADDR_W-1:0] tr_addr;
  logic [ENTRY_W-1:0] rd_top;
  logic [ENTRY_W-1:0] rd_tr;
  mv_entry_t         top_e;
  mv_entry_t         tr_e;
  nbr_flags_t        flags;
  logic signed [VEC_W-1:0] px;
  logic signed [VEC_W-1:0] py;
  logic [CNT_W-1:0]  cnt;

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign is_commit = (op_t'(op) == OP_COMMIT);
  assign finish    = busy && (!out_valid || out_ready);

  always_comb begin
    if (blocks_per_row == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(blocks_per_row) > CMP_W'(MAX_ROW_BLOCKS)) begin
      eff_w = CMP_W'(MAX_ROW_BLOCKS);
    end else begin
      eff_w = CMP_W'(blocks_per_row);
    end
  end

  always_comb begin
    done_e.x      = vec_x;
    done_e.y      = vec_y;
    done_e.motion = is_motion;
    col_inc       = CMP_W'(column) + CMP_W'(1);
    wrap          = col_inc >= eff_w;
    if (!is_commit || wrap) begin
      column_next = '0;
    end else begin
      column_next = column + ADDR_W'(1);
    end
    tr_addr = column_next + ADDR_W'(1);
  end

  mvp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ROW_BLOCKS)
  ) u_row_store (
    .clk    (clk),
    .we     (accept && is_commit),
    .waddr  (column),
    .wdata  (done_e),
    .re     (accept),
    .raddr0 (column_next),
    .raddr1 (tr_addr),
    .rdata0 (rd_top),
    .rdata1 (rd_tr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_row <= BPR_RESET;
    end else if (cfg_we) begin
      blocks_per_row <= cfg_wdata;
    end
  end

  // accept stage: commit, advance column, launch line-store reads
  always_ff @(posedge clk) begin
    if (rst) begin
      column           <= '0;
      past_first_row   <= 1'b0;
      left_entry       <= '0;
      upper_left_entry <= '0;
    end else if (accept) begin
      column <= column_next;
      if (!is_commit) begin
        past_first_row   <= 1'b0;
        left_entry       <= '0;
        upper_left_entry <= '0;
      end else if (wrap) begin
        past_first_row   <= 1'b1;
        left_entry       <= '0;
        upper_left_entry <= '0;
      end else begin
        left_entry       <= done_e;
        // top of the committed block was read when it was predicted
        upper_left_entry <= top_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // read and write of the same entry in one cycle: forward the new word
      fwd_top   <= is_commit && (column_next == column);
      fwd_tr    <= is_commit && (tr_addr == column);
      fwd_entry <= done_e;
      tr_ok     <= (CMP_W'(column_next) + CMP_W'(1)) < eff_w;
    end
  end

  assign top_e = fwd_top ? fwd_entry : mv_entry_t'(rd_top);
  assign tr_e  = fwd_tr  ? fwd_entry : mv_entry_t'(rd_tr);

  always_comb begin
    flags.col_nonzero    = (column != '0);
    flags.past_first_row = past_first_row;
    flags.tr_ok          = tr_ok;
  end

  mvp_predict u_predict (
    .left_e       (left_entry),
    .top_e        (top_e),
    .top_right_e  (tr_e),
    .upper_left_e (upper_left_entry),
    .flags        (flags),
    .pred_x       (px),
    .pred_y       (py),
    .count        (cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pred_x         <= px;
      pred_y         <= py;
      neighbor_count <= cnt;
      top_hold       <= top_e;
    end
  end

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && !busy)
    else $error("finished word did not reach output register");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !in_ready)
    else $error("word accepted without entering predict stage");

  a_zero_pred: assert property (@(posedge clk) disable iff (rst)
    (out_valid && neighbor_count == '0) |-> (pred_x == '0 && pred_y == '0))
    else $error("nonzero prediction with no neighbors");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_commit) |=> (column == '0 && !past_first_row))
    else $error("frame start did not reset position");

endmodule
